### sv/polygon_containment_area_centroid_core_assert.svh
// assertion macros for the polygon containment, area and centroid core
`ifndef POLYGON_CONTAINMENT_AREA_CENTROID_CORE_ASSERT_SVH
`define POLYGON_CONTAINMENT_AREA_CENTROID_CORE_ASSERT_SVH

// same-cycle implication, clocked on aclk, off during reset
`define PCAC_CHECK(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pcac check failed");

// next-cycle implication
`define PCAC_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pcac next-cycle check failed");

`endif

### sv/pcac_pkg.sv
// shared types for the polygon containment, area and centroid core
package pcac_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } cmd_t;

endpackage

### sv/polygon_containment_area_centroid_core.sv
// top level of the polygon containment, area and centroid core
//
//  channel | prefix | carries
//  --------+--------+--------------------------------------------------------
//  input   | s_     | action, coord_x, coord_y
//  result  | m_     | inside_res, twice_area, centroid_x, centroid_y,
//          |        | vertex_count, status
//
// clear, append and unknown actions load the result register straight from idle in the back end
// a query makes one store read per vertex, drains the product pipeline, then
// takes one quotient bit a cycle in the divider
// the front register and two-entry queue keep taking transfers while the back works
// aresetn clears the vertex count and all valid flags, the store itself is not cleared
module polygon_containment_area_centroid_core #(
    parameter int MAX_VERTICES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [15:0] s_coord_x,
    input  logic [15:0] s_coord_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_inside_res,
    output logic [38:0] m_twice_area,
    output logic [15:0] m_centroid_x,
    output logic [15:0] m_centroid_y,
    output logic [6:0]  m_vertex_count,
    output logic [1:0]  m_status
);
    import pcac_pkg::*;

    cmd_t front_cmd, back_cmd;
    logic front_valid, front_ready, back_valid, back_ready;

    pcac_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_coord_x (s_coord_x),
        .s_coord_y (s_coord_y),
        .cmd_o     (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    pcac_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_data  (front_cmd),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_data  (back_cmd),
        .rd_valid (back_valid),
        .rd_ready (back_ready)
    );

    pcac_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_i          (back_cmd),
        .cmd_valid      (back_valid),
        .cmd_ready      (back_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_inside_res   (m_inside_res),
        .m_twice_area   (m_twice_area),
        .m_centroid_x   (m_centroid_x),
        .m_centroid_y   (m_centroid_y),
        .m_vertex_count (m_vertex_count),
        .m_status       (m_status)
    );

endmodule

### sv/pcac_front.sv
// front end: takes input transfers and classifies the action into a command
module pcac_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [1:0]      s_action,
    input  logic [15:0]     s_coord_x,
    input  logic [15:0]     s_coord_y,
    output pcac_pkg::cmd_t  cmd_o,
    output logic            cmd_valid,
    input  logic            cmd_ready
);
    import pcac_pkg::*;

    logic  hold_vld_reg;
    cmd_t  hold_reg;
    op_t   op_dec;

    always_comb begin
        case (s_action)
            OP_CLEAR:  op_dec = OP_CLEAR;
            OP_APPEND: op_dec = OP_APPEND;
            OP_QUERY:  op_dec = OP_QUERY;
            default:   op_dec = OP_NOP;
        endcase
    end

    assign s_ready   = !hold_vld_reg || cmd_ready;
    assign cmd_valid = hold_vld_reg;
    assign cmd_o     = hold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            hold_vld_reg <= 1'b1;
            hold_reg.op  <= op_dec;
            hold_reg.x   <= s_coord_x;
            hold_reg.y   <= s_coord_y;
        end else if (cmd_ready) begin
            hold_vld_reg <= 1'b0;
        end
    end

endmodule

### sv/pcac_fifo.sv
// two-entry command queue between front and back
module pcac_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  pcac_pkg::cmd_t  wr_data,
    input  logic            wr_valid,
    output logic            wr_ready,
    output pcac_pkg::cmd_t  rd_data,
    output logic            rd_valid,
    input  logic            rd_ready
);
    import pcac_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       pop;

    assign wr_ready = fill_reg != 2'd2;
    assign rd_valid = fill_reg != 2'd0;
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                slot_reg[wr_ptr_reg] <= wr_data;
                wr_ptr_reg           <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

### sv/pcac_back.sv
// back end: vertex store, edge walk, area and crossing pipeline, mean divider
module pcac_back #(
    parameter int MAX_VERTICES = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pcac_pkg::cmd_t     cmd_i,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_inside_res,
    output logic [38:0]        m_twice_area,
    output logic [15:0]        m_centroid_x,
    output logic [15:0]        m_centroid_y,
    output logic [6:0]         m_vertex_count,
    output logic [1:0]         m_status
);
    import pcac_pkg::*;

    localparam int IW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int SW  = 17 + $clog2(MAX_VERTICES);
    localparam int DCW = $clog2(SW);
    localparam int AW  = (34 + $clog2(MAX_VERTICES) > 39) ? 34 + $clog2(MAX_VERTICES) : 39;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {S_IDLE, S_WALK, S_DRAIN, S_DIV, S_DONE} state_t;

    state_t state_reg;

    // vertex store
    logic [31:0]   mem [MAX_VERTICES];
    logic          wr_en;
    logic          rd_en;
    logic [31:0]   q_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] ra_reg;
    logic          q_vld_reg, q_first_reg, q_last_reg, close_reg;

    logic signed [15:0] px_reg, py_reg;
    logic [31:0]   first_reg, prev_reg;
    logic signed [SW-1:0] sx_reg, sy_reg;

    // edge stage: prev and cur vertices
    logic          e_vld_reg;
    logic signed [15:0] epx_reg, epy_reg, ecx_reg, ecy_reg;

    // product stage one
    logic          s1_vld_reg, s1_strad_reg;
    logic signed [31:0] p1_reg, p2_reg;
    logic signed [16:0] d_reg, dx_reg, dpy_reg, dpx_reg;

    // stage two
    logic          s2_vld_reg, s2_strad_reg, s2_dpos_reg;
    logic signed [33:0] num_reg, lhs_reg;
    logic signed [AW-1:0] acc_reg;
    logic          inside_reg;

    // divider
    logic [SW-1:0] magx_reg, magy_reg;
    logic [CW-1:0] remx_reg, remy_reg;
    logic          negx_reg, negy_reg;
    logic [DCW-1:0] dcnt_reg;
    logic [CW:0]   remx_sh, remy_sh;
    logic          qbx, qby;

    // output register
    logic          out_vld_reg, out_inside_reg;
    logic [38:0]   out_area_reg;
    logic [15:0]   out_cx_reg, out_cy_reg;
    logic [6:0]    out_count_reg;
    logic [1:0]    out_status_reg;

    logic          out_free;
    logic          out_load;
    logic          pop;
    logic [31:0]   edge_cur;
    logic [38:0]   area_sat;
    logic [15:0]   qx16, qy16;

    assign out_free  = !out_vld_reg || m_ready;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;
    assign pop       = cmd_valid && cmd_ready;
    assign out_load  = (pop && !((cmd_i.op == OP_QUERY) && (count_reg != '0)))
                       || ((state_reg == S_DONE) && out_free);
    assign wr_en     = pop && (cmd_i.op == OP_APPEND) && (count_reg < CW'(MAX_VERTICES));
    assign rd_en     = (state_reg == S_WALK) && (ra_reg < count_reg);
    assign edge_cur  = q_vld_reg ? q_reg : first_reg;

    assign remx_sh = {remx_reg, magx_reg[SW-1]};
    assign remy_sh = {remy_reg, magy_reg[SW-1]};
    assign qbx     = remx_sh >= {1'b0, count_reg};
    assign qby     = remy_sh >= {1'b0, count_reg};

    assign qx16 = negx_reg ? 16'(-magx_reg[15:0]) : magx_reg[15:0];
    assign qy16 = negy_reg ? 16'(-magy_reg[15:0]) : magy_reg[15:0];

    always_comb begin
        if (!acc_reg[AW-1] && (acc_reg[AW-1:38] != '0)) begin
            area_sat = {1'b0, {38{1'b1}}};
        end else if (acc_reg[AW-1] && (acc_reg[AW-1:38] != '1)) begin
            area_sat = {1'b1, 38'd0};
        end else begin
            area_sat = acc_reg[38:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[IW-1:0]] <= {cmd_i.y, cmd_i.x};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            q_reg <= mem[ra_reg[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
            q_vld_reg   <= 1'b0;
            close_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
        end else begin
            if (out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end

            q_vld_reg   <= rd_en;
            q_first_reg <= ra_reg == '0;
            q_last_reg  <= ra_reg == count_reg - CW'(1);
            if (rd_en) begin
                ra_reg <= ra_reg + CW'(1);
            end

            // edge forming
            e_vld_reg <= q_vld_reg ? !q_first_reg : close_reg;
            if (q_vld_reg) begin
                sx_reg   <= sx_reg + SW'($signed(q_reg[15:0]));
                sy_reg   <= sy_reg + SW'($signed(q_reg[31:16]));
                prev_reg <= q_reg;
                if (q_first_reg) begin
                    first_reg <= q_reg;
                end
                if (q_last_reg) begin
                    close_reg <= 1'b1;
                end
            end else if (close_reg) begin
                close_reg <= 1'b0;
                state_reg <= S_DRAIN;
            end
            epx_reg <= $signed(prev_reg[15:0]);
            epy_reg <= $signed(prev_reg[31:16]);
            ecx_reg <= $signed(edge_cur[15:0]);
            ecy_reg <= $signed(edge_cur[31:16]);

            // stage one: area products and differences
            s1_vld_reg   <= e_vld_reg;
            p1_reg       <= epx_reg * ecy_reg;
            p2_reg       <= ecx_reg * epy_reg;
            d_reg        <= 17'(epy_reg) - 17'(ecy_reg);
            dx_reg       <= 17'(epx_reg) - 17'(ecx_reg);
            dpy_reg      <= 17'(py_reg) - 17'(ecy_reg);
            dpx_reg      <= 17'(px_reg) - 17'(ecx_reg);
            s1_strad_reg <= (ecy_reg > py_reg) != (epy_reg > py_reg);

            // stage two: area sum and crossing products
            s2_vld_reg   <= s1_vld_reg;
            s2_strad_reg <= s1_strad_reg;
            s2_dpos_reg  <= d_reg > 17'sd0;
            num_reg      <= dx_reg * dpy_reg;
            lhs_reg      <= dpx_reg * d_reg;
            if (s1_vld_reg) begin
                acc_reg <= acc_reg + AW'(p1_reg) - AW'(p2_reg);
            end

            // stage three: crossing parity
            if (s2_vld_reg && s2_strad_reg &&
                (s2_dpos_reg ? (lhs_reg < num_reg) : (lhs_reg > num_reg))) begin
                inside_reg <= !inside_reg;
            end

            case (state_reg)
                S_IDLE: begin
                    if (pop) begin
                        out_inside_reg <= 1'b0;
                        out_area_reg   <= '0;
                        out_cx_reg     <= '0;
                        out_cy_reg     <= '0;
                        case (cmd_i.op)
                            OP_CLEAR: begin
                                count_reg      <= '0;
                                out_count_reg  <= '0;
                                out_status_reg <= ST_OK;
                            end
                            OP_APPEND: begin
                                if (count_reg < CW'(MAX_VERTICES)) begin
                                    count_reg      <= count_reg + CW'(1);
                                    out_count_reg  <= 7'(count_reg + CW'(1));
                                    out_status_reg <= ST_OK;
                                end else begin
                                    out_count_reg  <= 7'(count_reg);
                                    out_status_reg <= ST_FULL;
                                end
                            end
                            OP_QUERY: begin
                                out_count_reg <= 7'(count_reg);
                                if (count_reg == '0) begin
                                    out_status_reg <= ST_EMPTY;
                                end else begin
                                    out_status_reg <= ST_OK;
                                    px_reg         <= cmd_i.x;
                                    py_reg         <= cmd_i.y;
                                    ra_reg         <= '0;
                                    sx_reg         <= '0;
                                    sy_reg         <= '0;
                                    acc_reg        <= '0;
                                    inside_reg     <= 1'b0;
                                    state_reg      <= S_WALK;
                                end
                            end
                            default: begin
                                out_count_reg  <= 7'(count_reg);
                                out_status_reg <= ST_OK;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                end
                S_DRAIN: begin
                    if (!(e_vld_reg || s1_vld_reg || s2_vld_reg)) begin
                        magx_reg  <= sx_reg[SW-1] ? SW'(-sx_reg) : SW'(sx_reg);
                        magy_reg  <= sy_reg[SW-1] ? SW'(-sy_reg) : SW'(sy_reg);
                        negx_reg  <= sx_reg[SW-1];
                        negy_reg  <= sy_reg[SW-1];
                        remx_reg  <= '0;
                        remy_reg  <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    remx_reg <= qbx ? CW'(remx_sh - {1'b0, count_reg}) : CW'(remx_sh);
                    remy_reg <= qby ? CW'(remy_sh - {1'b0, count_reg}) : CW'(remy_sh);
                    magx_reg <= {magx_reg[SW-2:0], qbx};
                    magy_reg <= {magy_reg[SW-2:0], qby};
                    dcnt_reg <= dcnt_reg + DCW'(1);
                    if (dcnt_reg == DCW'(SW - 1)) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        out_inside_reg <= inside_reg;
                        out_area_reg   <= area_sat;
                        out_cx_reg     <= qx16;
                        out_cy_reg     <= qy16;
                        out_count_reg  <= 7'(count_reg);
                        out_status_reg <= ST_OK;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_inside_res   = out_inside_reg;
    assign m_twice_area   = out_area_reg;
    assign m_centroid_x   = out_cx_reg;
    assign m_centroid_y   = out_cy_reg;
    assign m_vertex_count = out_count_reg;
    assign m_status       = out_status_reg;

`include "polygon_containment_area_centroid_core_assert.svh"

    `PCAC_CHECK(count_in_range, 1'b1, count_reg <= CW'(MAX_VERTICES))
    `PCAC_CHECK(empty_has_no_vertices, out_vld_reg && (out_status_reg == ST_EMPTY), out_count_reg == 7'd0)
    `PCAC_NEXT(query_starts_walk, pop && (cmd_i.op == OP_QUERY) && (count_reg != '0), state_reg == S_WALK)
    `PCAC_CHECK(divide_after_drain, state_reg == S_DIV, !(q_vld_reg || e_vld_reg || s1_vld_reg || s2_vld_reg))

endmodule
